### sv/va3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_pkg
// Widths and constants shared by the 3D vector angle core and its channels.
// ----------------------------------------------------------------------------
package va3_pkg;

  localparam int CompW  = 16;
  localparam int AngleW = 15;

  localparam int CordicSteps = 20;
  localparam int ZW          = 26;

  localparam logic signed [ZW-1:0] HalfPiZ  = 26'sd1647099;
  localparam logic [AngleW-1:0]    AngleMax = 15'd25736;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic [AngleW-1:0]       angle_t;

  typedef logic signed [ZW-1:0] atan_tab_t [0:CordicSteps-1];

  localparam atan_tab_t AtanTab = '{
    26'sd823550, 26'sd486170, 26'sd256879, 26'sd130396, 26'sd65451,
    26'sd32757,  26'sd16383,  26'sd8192,   26'sd4096,   26'sd2048,
    26'sd1024,   26'sd512,    26'sd256,    26'sd128,    26'sd64,
    26'sd32,     26'sd16,     26'sd8,      26'sd4,      26'sd2
  };

endpackage

### sv/va3_pair_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_pair_if
// Channel carrying one pair of 3D vectors per beat.
// ----------------------------------------------------------------------------
interface va3_pair_if;
  logic           valid;
  logic           ready;
  va3_pkg::comp_t first_x;
  va3_pkg::comp_t first_y;
  va3_pkg::comp_t first_z;
  va3_pkg::comp_t second_x;
  va3_pkg::comp_t second_y;
  va3_pkg::comp_t second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface

### sv/va3_angle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_angle_if
// Channel carrying one angle result per beat.
// ----------------------------------------------------------------------------
interface va3_angle_if;
  logic            valid;
  logic            ready;
  va3_pkg::angle_t angle_rad;
  logic            zero_vector;

  modport source (output valid, angle_rad, zero_vector, input ready);
  modport sink (input valid, angle_rad, zero_vector, output ready);
endinterface

### sv/vector_angle_3d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_3d_core
// Angle between two 3D vectors: dot product, square root of the length
// product, restoring division, sine by square root, then a CORDIC run.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while no result beat waits on the output
// register; the square roots (one bit a stage), the division (one quotient
// bit a stage) and the CORDIC (one step a stage) are fully pipelined.
// Reset clears every stage valid bit; the whole pipe holds while a result
// beat waits on the output register.
module vector_angle_3d_core (
  input  logic      clk,
  input  logic      rst,
  va3_pair_if.sink  pair,
  va3_angle_if.source result
);

  localparam int LW = 32;   // length root
  localparam int SW = 16;   // sine root
  localparam int QW = 16;   // quotient
  localparam int RW = 50;   // division remainder
  localparam int XW = 34;   // CORDIC x, y
  localparam int N  = va3_pkg::CordicSteps;

  logic en;
  assign en = !result.valid || result.ready;
  assign pair.ready = en;

  // Stage 1: products
  logic               v1;
  logic signed [31:0] pd [0:2];
  logic signed [31:0] pa [0:2];
  logic signed [31:0] pb [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= pair.first_x * pair.second_x;
      pd[1] <= pair.first_y * pair.second_y;
      pd[2] <= pair.first_z * pair.second_z;
      pa[0] <= pair.first_x * pair.first_x;
      pa[1] <= pair.first_y * pair.first_y;
      pa[2] <= pair.first_z * pair.first_z;
      pb[0] <= pair.second_x * pair.second_x;
      pb[1] <= pair.second_y * pair.second_y;
      pb[2] <= pair.second_z * pair.second_z;
    end
  end

  // Stage 2: sums
  logic               v2;
  logic signed [33:0] dot;
  logic [31:0]        n1;
  logic [31:0]        n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot <= 34'(pd[0]) + 34'(pd[1]) + 34'(pd[2]);
      n1  <= $unsigned(pa[0]) + $unsigned(pa[1]) + $unsigned(pa[2]);
      n2  <= $unsigned(pb[0]) + $unsigned(pb[1]) + $unsigned(pb[2]);
    end
  end

  // Stage 3 feeds the length root: product of squared lengths and |dot|.
  logic          sa_v    [0:LW];
  logic [33:0]   sa_rem  [0:LW];
  logic [LW-1:0] sa_root [0:LW];
  logic [63:0]   sa_arg  [0:LW];
  logic [33:0]   sa_mag  [0:LW];
  logic          sa_neg  [0:LW];
  logic          sa_zero [0:LW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v[0] <= 1'b0;
    end else if (en) begin
      sa_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_rem[0]  <= '0;
      sa_root[0] <= '0;
      sa_arg[0]  <= n1 * n2;
      sa_mag[0]  <= dot[33] ? $unsigned(-dot) : $unsigned(dot);
      sa_neg[0]  <= dot[33];
      sa_zero[0] <= (n1 == '0) || (n2 == '0);
    end
  end

  for (genvar i = 0; i < LW; i++) begin : g_len_root
    logic [33:0] acc;
    logic [33:0] trial;
    logic        ge;
    assign acc   = {sa_rem[i][31:0], sa_arg[i][63:62]};
    assign trial = {sa_root[i], 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sa_v[i+1] <= 1'b0;
      end else if (en) begin
        sa_v[i+1] <= sa_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa_rem[i+1]  <= ge ? acc - trial : acc;
        sa_root[i+1] <= {sa_root[i][LW-2:0], ge};
        sa_arg[i+1]  <= {sa_arg[i][61:0], 2'b00};
        sa_mag[i+1]  <= sa_mag[i];
        sa_neg[i+1]  <= sa_neg[i];
        sa_zero[i+1] <= sa_zero[i];
      end
    end
  end

  // Division: rounded |dot| * 2^15 / L, one quotient bit a stage.
  logic          db_v    [0:QW];
  logic [RW-1:0] db_r    [0:QW];
  logic [LW-1:0] db_len  [0:QW];
  logic [QW-1:0] db_q    [0:QW];
  logic          db_neg  [0:QW];
  logic          db_zero [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      db_v[0] <= 1'b0;
    end else if (en) begin
      db_v[0] <= sa_v[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db_r[0]    <= {1'b0, sa_mag[LW], 15'b0} + RW'(sa_root[LW][LW-1:1]);
      db_len[0]  <= sa_root[LW];
      db_q[0]    <= '0;
      db_neg[0]  <= sa_neg[LW];
      db_zero[0] <= sa_zero[LW];
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int K = QW - 1 - i;
    logic [RW-1:0] dv;
    logic          ge;
    assign dv = RW'(db_len[i]) << K;
    assign ge = db_r[i] >= dv;

    always_ff @(posedge clk) begin
      if (rst) begin
        db_v[i+1] <= 1'b0;
      end else if (en) begin
        db_v[i+1] <= db_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        db_r[i+1]    <= ge ? db_r[i] - dv : db_r[i];
        db_q[i+1]    <= db_q[i] | (QW'(ge) << K);
        db_len[i+1]  <= db_len[i];
        db_neg[i+1]  <= db_neg[i];
        db_zero[i+1] <= db_zero[i];
      end
    end
  end

  // Signed cosine in Q1.15, clamped to one in magnitude.
  logic               cv;
  logic signed [16:0] cos_q;
  logic               cz;
  logic [16:0]        qc;

  assign qc = (db_q[QW] > QW'(32768)) ? 17'd32768 : {1'b0, db_q[QW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (en) begin
      cv <= db_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= db_neg[QW] ? -$signed(qc) : $signed(qc);
      cz    <= db_zero[QW];
    end
  end

  // Sine root of 2^30 - c^2, one bit a stage.
  logic               sb_v    [0:SW];
  logic [17:0]        sb_rem  [0:SW];
  logic [SW-1:0]      sb_root [0:SW];
  logic [31:0]        sb_arg  [0:SW];
  logic signed [16:0] sb_c    [0:SW];
  logic               sb_zero [0:SW];
  logic signed [33:0] csq;

  assign csq = cos_q * cos_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v[0] <= 1'b0;
    end else if (en) begin
      sb_v[0] <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_rem[0]  <= '0;
      sb_root[0] <= '0;
      sb_arg[0]  <= 32'h4000_0000 - 32'(csq);
      sb_c[0]    <= cos_q;
      sb_zero[0] <= cz;
    end
  end

  for (genvar i = 0; i < SW; i++) begin : g_sin_root
    logic [17:0] acc;
    logic [17:0] trial;
    logic        ge;
    assign acc   = {sb_rem[i][15:0], sb_arg[i][31:30]};
    assign trial = {sb_root[i], 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_v[i+1] <= 1'b0;
      end else if (en) begin
        sb_v[i+1] <= sb_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_rem[i+1]  <= ge ? acc - trial : acc;
        sb_root[i+1] <= {sb_root[i][SW-2:0], ge};
        sb_arg[i+1]  <= {sb_arg[i][29:0], 2'b00};
        sb_c[i+1]    <= sb_c[i];
        sb_zero[i+1] <= sb_zero[i];
      end
    end
  end

  // CORDIC vectoring; a negative cosine is first turned by a quarter.
  logic                   cr_v    [0:N];
  logic signed [XW-1:0]   cr_x    [0:N];
  logic signed [XW-1:0]   cr_y    [0:N];
  logic signed [va3_pkg::ZW-1:0] cr_z [0:N];
  logic                   cr_zero [0:N];
  logic signed [XW-1:0]   x0;
  logic signed [XW-1:0]   y0;

  assign x0 = {{3{sb_c[SW][16]}}, sb_c[SW], 14'b0};
  assign y0 = {4'b0, sb_root[SW], 14'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_v[0] <= 1'b0;
    end else if (en) begin
      cr_v[0] <= sb_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (x0[XW-1]) begin
        cr_x[0] <= y0;
        cr_y[0] <= -x0;
        cr_z[0] <= va3_pkg::HalfPiZ;
      end else begin
        cr_x[0] <= x0;
        cr_y[0] <= y0;
        cr_z[0] <= '0;
      end
      cr_zero[0] <= sb_zero[SW];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 up;
    // Shifts truncate toward zero, as a magnitude shift would.
    assign dx = cr_x[i][XW-1] ? -$signed((-cr_x[i]) >>> i) : (cr_x[i] >>> i);
    assign dy = cr_y[i][XW-1] ? -$signed((-cr_y[i]) >>> i) : (cr_y[i] >>> i);
    assign up = !cr_y[i][XW-1] && (cr_y[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        cr_v[i+1] <= 1'b0;
      end else if (en) begin
        cr_v[i+1] <= cr_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (up) begin
          cr_x[i+1] <= cr_x[i] + dy;
          cr_y[i+1] <= cr_y[i] - dx;
          cr_z[i+1] <= cr_z[i] + va3_pkg::AtanTab[i];
        end else begin
          cr_x[i+1] <= cr_x[i] - dy;
          cr_y[i+1] <= cr_y[i] + dx;
          cr_z[i+1] <= cr_z[i] - va3_pkg::AtanTab[i];
        end
        cr_zero[i+1] <= cr_zero[i];
      end
    end
  end

  // Output register: round to Q6.9 and saturate at AngleMax.
  logic [va3_pkg::ZW-1:0] zpos;
  logic [va3_pkg::ZW-1:0] zrnd;
  logic [14:0]            ang;

  assign zpos = cr_z[N][va3_pkg::ZW-1] ? '0 : $unsigned(cr_z[N]);
  assign zrnd = zpos + va3_pkg::ZW'(1024);
  assign ang  = (zrnd[va3_pkg::ZW-1:11] > 15'(va3_pkg::AngleMax)) ?
                va3_pkg::AngleMax : zrnd[va3_pkg::ZW-1:11];

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= cr_v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.angle_rad   <= cr_zero[N] ? '0 : ang;
      result.zero_vector <= cr_zero[N];
    end
  end

endmodule
